[rtl/fpa_pkg.sv]
`timescale 1ns / 1ps
package fpa_pkg;

  // command codes
  localparam logic [3:0] CMD_ADD      = 4'd0;
  localparam logic [3:0] CMD_SUB      = 4'd1;
  localparam logic [3:0] CMD_MUL      = 4'd2;
  localparam logic [3:0] CMD_DIV      = 4'd3;
  localparam logic [3:0] CMD_MIN      = 4'd4;
  localparam logic [3:0] CMD_MAX      = 4'd5;
  localparam logic [3:0] CMD_INC      = 4'd6;
  localparam logic [3:0] CMD_DEC      = 4'd7;
  localparam logic [3:0] CMD_TO_INT   = 4'd8;
  localparam logic [3:0] CMD_FROM_INT = 4'd9;

  // saturation bounds of the 32-bit result word
  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  // request state carried down the pipeline
  typedef struct packed {
    logic [3:0]  cmd;
    logic        neg;     // product or quotient is negative
    logic [31:0] mag_a;
    logic [31:0] mag_b;
    logic [63:0] prod;    // |a| * |b|, filled by the multiply stage
    logic [31:0] value;   // result of the commands that need no multiply or divide
    logic        ovf;
    logic        dz;
    logic        gt;
    logic        lt;
    logic        eq;
  } pkt_t;

endpackage

[rtl/fpa_prep.sv]
`timescale 1ns / 1ps
module fpa_prep #(
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        in_valid,
  input  logic [3:0]                  command,
  input  logic signed [31:0]          operand_a,
  input  logic signed [31:0]          operand_b,
  output logic                        out_valid,
  output fpa_pkg::pkt_t               out_pkt,
  output logic [FRAC_BITS+63:0]       out_work
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int W  = NW + 32;

  logic [32:0]   add_sum;
  logic [32:0]   sub_sum;
  logic [32:0]   inc_sum;
  logic [32:0]   dec_sum;
  logic [FRAC_BITS:0] fi_top;
  logic          fi_ovf;
  logic          gt;
  logic          lt;
  fpa_pkg::pkt_t pkt_next;
  logic [W-1:0]  work_next;

  // saturate a 33-bit sum into the 32-bit range
  function automatic logic [32:0] sat33(input logic [32:0] s);
    logic [32:0] r;
    begin
      if (s[32] != s[31]) begin
        r = {1'b1, (s[32] ? fpa_pkg::Q_MIN : fpa_pkg::Q_MAX)};
      end else begin
        r = {1'b0, s[31:0]};
      end
      return r;
    end
  endfunction

  // compute the results that need no multiply or divide, and the operand magnitudes
  always_comb begin
    add_sum = {operand_a[31], operand_a} + {operand_b[31], operand_b};
    sub_sum = {operand_a[31], operand_a} - {operand_b[31], operand_b};
    inc_sum = {operand_a[31], operand_a} + 33'd1;
    dec_sum = {operand_a[31], operand_a} - 33'd1;
    fi_top  = operand_a[31:31-FRAC_BITS];
    fi_ovf  = (|fi_top) && !(&fi_top);
    gt      = operand_a > operand_b;
    lt      = operand_a < operand_b;

    pkt_next       = '0;
    pkt_next.cmd   = command;
    pkt_next.gt    = gt;
    pkt_next.lt    = lt;
    pkt_next.eq    = operand_a == operand_b;
    pkt_next.neg   = operand_a[31] ^ operand_b[31];
    pkt_next.mag_a = operand_a[31] ? 32'(-operand_a) : operand_a;
    pkt_next.mag_b = operand_b[31] ? 32'(-operand_b) : operand_b;
    pkt_next.dz    = (command == fpa_pkg::CMD_DIV) && (operand_b == 32'sd0);

    case (command)
      fpa_pkg::CMD_ADD: {pkt_next.ovf, pkt_next.value} = sat33(add_sum);
      fpa_pkg::CMD_SUB: {pkt_next.ovf, pkt_next.value} = sat33(sub_sum);
      fpa_pkg::CMD_INC: {pkt_next.ovf, pkt_next.value} = sat33(inc_sum);
      fpa_pkg::CMD_DEC: {pkt_next.ovf, pkt_next.value} = sat33(dec_sum);
      fpa_pkg::CMD_MIN: pkt_next.value = lt ? operand_a : operand_b;
      fpa_pkg::CMD_MAX: pkt_next.value = gt ? operand_a : operand_b;
      fpa_pkg::CMD_TO_INT: pkt_next.value = operand_a >>> FRAC_BITS;
      fpa_pkg::CMD_FROM_INT: begin
        pkt_next.ovf = fi_ovf;
        if (fi_ovf) begin
          pkt_next.value = operand_a[31] ? fpa_pkg::Q_MIN : fpa_pkg::Q_MAX;
        end else begin
          pkt_next.value = operand_a << FRAC_BITS;
        end
      end
      default: pkt_next.value = '0;
    endcase

    // divider start: zero remainder, numerator |a| * 2^FRAC_BITS
    work_next = {32'd0, pkt_next.mag_a, {FRAC_BITS{1'b0}}};
  end

  // advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_pkt  <= pkt_next;
      out_work <= work_next;
    end
  end

endmodule

[rtl/fpa_mul.sv]
`timescale 1ns / 1ps
module fpa_mul #(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  in_valid,
  input  fpa_pkg::pkt_t         in_pkt,
  input  logic [FRAC_BITS+63:0] in_work,
  output logic                  out_valid,
  output fpa_pkg::pkt_t         out_pkt,
  output logic [FRAC_BITS+63:0] out_work
);

  fpa_pkg::pkt_t pkt_next;

  // form the unsigned product of the magnitudes
  always_comb begin
    pkt_next      = in_pkt;
    pkt_next.prod = 64'(in_pkt.mag_a) * 64'(in_pkt.mag_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_pkt  <= pkt_next;
      out_work <= in_work;
    end
  end

endmodule

[rtl/fpa_div_step.sv]
`timescale 1ns / 1ps
module fpa_div_step #(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  in_valid,
  input  fpa_pkg::pkt_t         in_pkt,
  input  logic [FRAC_BITS+63:0] in_work,
  output logic                  out_valid,
  output fpa_pkg::pkt_t         out_pkt,
  output logic [FRAC_BITS+63:0] out_work
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int W  = NW + 32;

  logic [W:0]    shifted;
  logic [32:0]   trial;
  logic          fits;
  logic [W-1:0]  work_next;

  // shift in one numerator bit, subtract the divisor where it fits
  always_comb begin
    shifted = {in_work, 1'b0};
    trial   = shifted[W:NW];
    fits    = trial >= {1'b0, in_pkt.mag_b};
    if (fits) begin
      work_next = {32'(trial - {1'b0, in_pkt.mag_b}), shifted[NW-1:1], 1'b1};
    end else begin
      work_next = {trial[31:0], shifted[NW-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_pkt  <= in_pkt;
      out_work <= work_next;
    end
  end

endmodule

[rtl/fpa_out.sv]
`timescale 1ns / 1ps
module fpa_out #(
  parameter int FRAC_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  in_valid,
  input  fpa_pkg::pkt_t         in_pkt,
  input  logic [FRAC_BITS+63:0] in_work,
  output logic                  out_valid,
  output logic signed [31:0]    result_value,
  output logic                  a_greater,
  output logic                  a_less,
  output logic                  a_equal,
  output logic                  divide_by_zero,
  output logic                  overflow
);

  localparam int NW = 32 + FRAC_BITS;

  logic [63:0] mul_sum;
  logic [63:0] mul_mag;
  logic [31:0] rem;
  logic        round_up;
  logic [63:0] div_mag;
  logic [63:0] mag;
  logic [63:0] limit;
  logic [31:0] value_next;
  logic        ovf_next;

  // for multiply and divide, round half away from zero on the magnitude, then saturate with sign
  always_comb begin
    mul_sum  = in_pkt.prod + (64'd1 << (FRAC_BITS - 1));
    mul_mag  = mul_sum >> FRAC_BITS;
    rem      = in_work[NW+31:NW];
    round_up = {rem, 1'b0} >= {1'b0, in_pkt.mag_b};
    div_mag  = 64'(in_work[NW-1:0]) + 64'(round_up);
    mag      = (in_pkt.cmd == fpa_pkg::CMD_MUL) ? mul_mag : div_mag;
    limit    = in_pkt.neg ? 64'(fpa_pkg::Q_MIN) : 64'(fpa_pkg::Q_MAX);

    value_next = in_pkt.value;
    ovf_next   = in_pkt.ovf;
    if ((in_pkt.cmd == fpa_pkg::CMD_MUL) ||
        ((in_pkt.cmd == fpa_pkg::CMD_DIV) && !in_pkt.dz)) begin
      if (mag > limit) begin
        ovf_next   = 1'b1;
        value_next = in_pkt.neg ? fpa_pkg::Q_MIN : fpa_pkg::Q_MAX;
      end else begin
        ovf_next   = 1'b0;
        value_next = in_pkt.neg ? 32'(-mag[31:0]) : mag[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      result_value   <= value_next;
      a_greater      <= in_pkt.gt;
      a_less         <= in_pkt.lt;
      a_equal        <= in_pkt.eq;
      divide_by_zero <= in_pkt.dz;
      overflow       <= ovf_next;
    end
  end

endmodule

[rtl/fixed_point_alu_top.sv]
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | command, operand_a, operand_b
// output  | out_valid | out_stall | result_value, a_greater, a_less, a_equal,
//         |           |           | divide_by_zero, overflow
//
// One request enters per cycle while in_stall is low; each request passes the
// prep, multiply, divider and output stages in order. The divider resolves one
// quotient bit per stage over 32 + FRAC_BITS stages.
// Reset clears the valid bit of every stage; nothing else is cleared.
// A stall holds only stages that hold a request: empty stages keep filling, so
// in_stall rises only when every stage is full and out_stall is high.
module fixed_point_alu_top #(
  parameter int FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         command,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               a_greater,
  output logic               a_less,
  output logic               a_equal,
  output logic               divide_by_zero,
  output logic               overflow
);

  localparam int NW = 32 + FRAC_BITS;
  localparam int W  = NW + 32;
  localparam int L  = NW + 3;

  logic [L-1:0]  vld;
  logic [L:0]    free;
  fpa_pkg::pkt_t pkt  [L-1];
  logic [W-1:0]  work [L-1];

  // a stage may load when it is empty or its successor takes its request
  assign free[L] = !out_stall;
  for (genvar k = 0; k < L; k++) begin : g_free
    assign free[k] = !vld[k] || free[k+1];
  end

  assign in_stall  = !free[0];
  assign out_valid = vld[L-1];

  fpa_prep #(.FRAC_BITS(FRAC_BITS)) u_prep (
    .clk       (clk),
    .rst       (rst),
    .load      (free[0]),
    .in_valid  (in_valid),
    .command   (command),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .out_valid (vld[0]),
    .out_pkt   (pkt[0]),
    .out_work  (work[0])
  );

  fpa_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk       (clk),
    .rst       (rst),
    .load      (free[1]),
    .in_valid  (vld[0]),
    .in_pkt    (pkt[0]),
    .in_work   (work[0]),
    .out_valid (vld[1]),
    .out_pkt   (pkt[1]),
    .out_work  (work[1])
  );

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < NW; i++) begin : g_div
    fpa_div_step #(.FRAC_BITS(FRAC_BITS)) u_step (
      .clk       (clk),
      .rst       (rst),
      .load      (free[i+2]),
      .in_valid  (vld[i+1]),
      .in_pkt    (pkt[i+1]),
      .in_work   (work[i+1]),
      .out_valid (vld[i+2]),
      .out_pkt   (pkt[i+2]),
      .out_work  (work[i+2])
    );
  end

  fpa_out #(.FRAC_BITS(FRAC_BITS)) u_out (
    .clk            (clk),
    .rst            (rst),
    .load           (free[L-1]),
    .in_valid       (vld[L-2]),
    .in_pkt         (pkt[L-2]),
    .in_work        (work[L-2]),
    .out_valid      (vld[L-1]),
    .result_value   (result_value),
    .a_greater      (a_greater),
    .a_less         (a_less),
    .a_equal        (a_equal),
    .divide_by_zero (divide_by_zero),
    .overflow       (overflow)
  );

  // exactly one compare outcome per result
  a_cmp_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_greater, a_less, a_equal}))
    else $error("compare flags not one-hot");

  // a zero divisor gives a zero result without overflow
  a_dz_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && divide_by_zero) |-> (result_value == 32'sd0 && !overflow))
    else $error("divide by zero result wrong");

  // input backs up only when the pipeline is full and the output is stalled
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled with room in the pipeline");

endmodule

[tb/fixed_point_alu_top_tb.sv]
`timescale 1ns / 1ps
module fixed_point_alu_top_tb;

  localparam int FRAC = 8;
  localparam int LATENCY = FRAC + 35;
  localparam int RANDOM_REQUESTS = 725;
  localparam int QUIET_TAIL = 120;
  localparam int LONG_HOLD = 200;
  localparam int LONG_HOLD_AT = 250;
  localparam int REPORT_LIMIT = 10;

  // command codes the block leaves unused
  localparam logic [3:0] CMD_UNUSED_LO = 4'd10;
  localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

  typedef struct packed {
    logic [3:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] b;
  } alu_request_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               gt;
    logic               lt;
    logic               eq;
    logic               dz;
    logic               ovf;
  } alu_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [3:0]         command = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] result_value;
  logic               a_greater;
  logic               a_less;
  logic               a_equal;
  logic               divide_by_zero;
  logic               overflow;

  alu_request_t queued_requests[$];
  alu_result_t  expected_results[$];
  alu_request_t next_req;
  alu_result_t  want;

  int n_requests = 0;
  int n_directed = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_blocked = 0;
  int n_errors = 0;
  int send_gap = 0;
  int recv_burst = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  logic quiet;

  fixed_point_alu_top #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .command(command), .operand_a(operand_a), .operand_b(operand_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .result_value(result_value), .a_greater(a_greater), .a_less(a_less),
    .a_equal(a_equal), .divide_by_zero(divide_by_zero), .overflow(overflow)
  );

  // no idling over the last stretch of the run
  assign quiet = (n_accepted + QUIET_TAIL >= n_requests);

  initial begin
    forever #5 clk = ~clk;
  end

  // compute the ALU result word and flags for one request
  function automatic alu_result_t alu_predict(logic [3:0] cmd, logic signed [31:0] a,
                                              logic signed [31:0] b);
    alu_result_t r;
    longint sa, sb, wide;
    logic [63:0] mag_n, mag_d, q;
    bit neg;
    sa = a;
    sb = b;
    wide = 0;
    r = '0;
    case (cmd)
      fpa_pkg::CMD_ADD: wide = sa + sb;
      fpa_pkg::CMD_SUB: wide = sa - sb;
      fpa_pkg::CMD_MUL: begin
        wide = sa * sb;
        neg = wide < 0;
        mag_n = neg ? -wide : wide;
        mag_n = (mag_n + (64'd1 << (FRAC - 1))) >> FRAC;
        wide = neg ? -longint'(mag_n) : longint'(mag_n);
      end
      fpa_pkg::CMD_DIV: begin
        if (sb == 0) begin
          r.dz = 1'b1;
        end else begin
          mag_n = sa < 0 ? -sa : sa;
          mag_n = mag_n << FRAC;
          mag_d = sb < 0 ? -sb : sb;
          // round half away from zero on the magnitude
          q = (64'd2 * mag_n + mag_d) / (64'd2 * mag_d);
          neg = (sa < 0) != (sb < 0);
          wide = neg ? -longint'(q) : longint'(q);
        end
      end
      fpa_pkg::CMD_MIN: wide = (sa <= sb) ? sa : sb;
      fpa_pkg::CMD_MAX: wide = (sa >= sb) ? sa : sb;
      fpa_pkg::CMD_INC: wide = sa + 1;
      fpa_pkg::CMD_DEC: wide = sa - 1;
      fpa_pkg::CMD_TO_INT: wide = sa >>> FRAC;
      fpa_pkg::CMD_FROM_INT: wide = sa * (longint'(1) << FRAC);
      default: wide = 0;
    endcase
    // clamp to the 32-bit range
    if (wide > longint'($signed(fpa_pkg::Q_MAX))) begin
      r.value = fpa_pkg::Q_MAX;
      r.ovf = 1'b1;
    end else if (wide < longint'($signed(fpa_pkg::Q_MIN))) begin
      r.value = fpa_pkg::Q_MIN;
      r.ovf = 1'b1;
    end else begin
      r.value = wide[31:0];
    end
    r.gt = sa > sb;
    r.lt = sa < sb;
    r.eq = sa == sb;
    return r;
  endfunction

  function automatic logic signed [31:0] pick_operand();
    logic signed [31:0] v;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: v = fpa_pkg::Q_MAX;
          1: v = fpa_pkg::Q_MIN;
          2: v = 0;
          3: v = 1;
          default: v = -1;
        endcase
      end
      1, 2, 3: v = $signed($urandom_range(0, 8191)) - 4096;
      4, 5: v = $signed($urandom) >>> 11;
      default: v = $urandom;
    endcase
    return v;
  endfunction

  task automatic add_request(logic [3:0] cmd, logic signed [31:0] a, logic signed [31:0] b);
    alu_request_t req;
    req.cmd = cmd;
    req.a = a;
    req.b = b;
    queued_requests.push_back(req);
  endtask

  task automatic report_failure(string what);
    n_errors++;
    if (n_errors <= REPORT_LIMIT)
      $display("[%0t] %s", $time, what);
  endtask

  // drive requests; record the expected result of each accepted one
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(alu_predict(command, operand_a, operand_b));
        n_accepted <= n_accepted + 1;
      end
      if (in_valid && in_stall)
        n_blocked <= n_blocked + 1;
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (!quiet && queued_requests.size() != 0 && $urandom_range(0, 9) == 0) begin
          send_gap = $urandom_range(1, 6) - 1;
          in_valid <= 1'b0;
        end else if (queued_requests.size() != 0) begin
          next_req = queued_requests.pop_front();
          in_valid <= 1'b1;
          command <= next_req.cmd;
          operand_a <= next_req.a;
          operand_b <= next_req.b;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // hold off the output in bursts, and once for a long stretch to fill the pipe
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_burst = 0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && n_accepted >= LONG_HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_stall <= 1'b1;
    end else if (recv_burst > 0) begin
      recv_burst--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      recv_burst = $urandom_range(1, 6) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // check each result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_failure($sformatf("result with nothing expected: value %h", result_value));
      end else begin
        want = expected_results.pop_front();
        n_checked <= n_checked + 1;
        if (result_value !== want.value || a_greater !== want.gt || a_less !== want.lt ||
            a_equal !== want.eq || divide_by_zero !== want.dz || overflow !== want.ovf)
          report_failure($sformatf({"mismatch: expected value %h gt%b lt%b eq%b dz%b ov%b,",
                                    " got %h gt%b lt%b eq%b dz%b ov%b"},
            want.value, want.gt, want.lt, want.eq, want.dz, want.ovf,
            result_value, a_greater, a_less, a_equal, divide_by_zero, overflow));
      end
    end
  end

  initial begin
    logic [3:0] cmd;
    logic signed [31:0] a, b;
    int guard;

    // directed: range limits, rounding ties, divide by zero, unused codes
    add_request(fpa_pkg::CMD_ADD, fpa_pkg::Q_MAX, 1);
    add_request(fpa_pkg::CMD_ADD, fpa_pkg::Q_MIN, -1);
    add_request(fpa_pkg::CMD_SUB, fpa_pkg::Q_MIN, 1);
    add_request(fpa_pkg::CMD_SUB, fpa_pkg::Q_MAX, -1);
    add_request(fpa_pkg::CMD_MUL, fpa_pkg::Q_MAX, fpa_pkg::Q_MAX);
    add_request(fpa_pkg::CMD_MUL, fpa_pkg::Q_MIN, fpa_pkg::Q_MAX);
    add_request(fpa_pkg::CMD_MUL, 1, 128);
    add_request(fpa_pkg::CMD_MUL, -1, 128);
    add_request(fpa_pkg::CMD_DIV, 300, 0);
    add_request(fpa_pkg::CMD_DIV, 1, 512);
    add_request(fpa_pkg::CMD_DIV, -1, 512);
    add_request(fpa_pkg::CMD_DIV, fpa_pkg::Q_MIN, -1);
    add_request(fpa_pkg::CMD_MIN, 5, 5);
    add_request(fpa_pkg::CMD_MAX, -3, 7);
    add_request(fpa_pkg::CMD_MIN, fpa_pkg::Q_MIN, fpa_pkg::Q_MAX);
    add_request(fpa_pkg::CMD_INC, fpa_pkg::Q_MAX, 0);
    add_request(fpa_pkg::CMD_DEC, fpa_pkg::Q_MIN, 0);
    add_request(fpa_pkg::CMD_INC, -1, 3);
    add_request(fpa_pkg::CMD_DEC, 0, -9);
    add_request(fpa_pkg::CMD_TO_INT, -257, 0);
    add_request(fpa_pkg::CMD_TO_INT, fpa_pkg::Q_MAX, fpa_pkg::Q_MIN);
    add_request(fpa_pkg::CMD_FROM_INT, 32'sh0080_0000, 1);
    add_request(fpa_pkg::CMD_FROM_INT, -32'sh0080_0000, 1);
    add_request(CMD_UNUSED_LO, fpa_pkg::Q_MAX, fpa_pkg::Q_MIN);
    add_request(CMD_UNUSED_HI, 0, 0);
    n_directed = queued_requests.size();

    // random: mostly defined commands, with equal operands and zero divisors mixed in
    repeat (RANDOM_REQUESTS) begin
      if ($urandom_range(0, 19) == 0)
        cmd = 4'($urandom);
      else
        cmd = 4'($urandom_range(fpa_pkg::CMD_ADD, fpa_pkg::CMD_FROM_INT));
      a = pick_operand();
      b = ($urandom_range(0, 9) == 0) ? a : pick_operand();
      if (cmd == fpa_pkg::CMD_DIV && $urandom_range(0, 7) == 0)
        b = 0;
      add_request(cmd, a, b);
    end
    n_requests = queued_requests.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // wait for every request to go in, then for the pipe to drain
    while (n_accepted != n_requests) @(negedge clk);
    guard = 0;
    while (expected_results.size() != 0 && guard < 100 * LATENCY) begin
      guard++;
      @(negedge clk);
    end
    repeat (LATENCY + 10) @(negedge clk);

    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));

    $display("Sent %0d requests (%0d directed, rest random) and checked %0d results;",
             n_requests, n_directed, n_checked);
    $display("input was held off for %0d cycles, %0d mismatches seen", n_blocked, n_errors);
    if (n_errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
